/* hdl/itfmt_pkg.sv */
// Shared types, codes and the digit-to-ASCII function of the integer formatter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package itfmt_pkg;

	typedef enum logic [1:0] {
		OP_SDEC = 2'd0,
		OP_UDEC = 2'd1,
		OP_HEXL = 2'd2,
		OP_HEXU = 2'd3
	} op_t;

	// classification carried with the magnitude through the middle queue
	typedef struct packed {
		logic neg;
		op_t  op;
	} cls_t;

	// one output beat
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [4:0] count;
	} char_t;

	localparam int DEC_BITS   = 32;
	localparam int DEC_DIGITS = 10;
	localparam logic [4:0] MAX_CHARS = 5'd16;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER : CH_LOWER;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'd0, d};
		else
			digit_char = base + {4'd0, d} - 8'd10;
	endfunction

endpackage
`default_nettype wire

/* hdl/itfmt_fifo.sv */
// Small register FIFO used between the front, the back and the result port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module itfmt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : AW'(wr_q + 1'b1);
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : AW'(rd_q + 1'b1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

/* hdl/itfmt_front.sv */
// Front end: takes an input beat, forms the magnitude and sign for its mode.
// Depends on itfmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itfmt_front import itfmt_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic [63:0]            value,
	input  wire logic [1:0]             op,
	output logic [VALUE_WIDTH-1:0]      mag,
	output cls_t                        cls
);
	logic [DEC_BITS-1:0] low;

	assign low = value[DEC_BITS-1:0];

	always_comb begin
		cls.op  = op_t'(op);
		cls.neg = 1'b0;
		mag     = value[VALUE_WIDTH-1:0];
		unique case (op_t'(op))
			OP_SDEC: begin
				cls.neg = low[DEC_BITS-1];
				// two's complement negate in 32 bits keeps the minimum value exact
				mag = VALUE_WIDTH'(low[DEC_BITS-1] ? DEC_BITS'(-low) : low);
			end
			OP_UDEC: mag = VALUE_WIDTH'(low);
			OP_HEXL, OP_HEXU: mag = value[VALUE_WIDTH-1:0];
			default: mag = value[VALUE_WIDTH-1:0];
		endcase
	end
endmodule
`default_nettype wire

/* hdl/itfmt_back.sv */
// Back end: double-dabble decimal conversion or hex nibble load, then
// leading-zero scan and character emission. Depends on itfmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itfmt_back import itfmt_pkg::*; #(
	parameter int VALUE_WIDTH = 64,
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_empty,
	output logic                        in_pop,
	input  wire logic [VALUE_WIDTH-1:0] in_mag,
	input  cls_t                        in_cls,
	input  wire logic                   out_full,
	output logic                        out_push,
	output char_t                       out_item
);
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int PADN = (HEX_DIGITS > DIGIT_SLOTS) ? HEX_DIGITS : DIGIT_SLOTS;
	localparam int PW = $clog2(DIGIT_SLOTS);

	typedef enum logic [1:0] {IDLE, DEC, SCAN, EMIT} state_t;

	state_t                   state_q;
	logic [4*DEC_DIGITS-1:0]  bcd_q;
	logic [DEC_BITS-1:0]      shift_q;
	logic [4:0]               bit_cnt_q;
	logic [3:0]               digits_q [DIGIT_SLOTS];
	logic                     neg_q, upper_q, dash_q, ovf_q;
	logic [PW-1:0]            pos_q;
	logic [4:0]               emit_cnt_q, total_q;

	logic [4*DEC_DIGITS-1:0]  bcd_adj, bcd_next;
	logic [4*DIGIT_SLOTS-1:0] dec_pad;
	logic [4*PADN-1:0]        hex_pad;
	logic                     hex_ovf;
	logic [PW-1:0]            msd;
	logic [4:0]               sum;
	logic                     is_last;

	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++)
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		bcd_next = {bcd_adj[4*DEC_DIGITS-2:0], shift_q[DEC_BITS-1]};
	end

	assign dec_pad = (4*DIGIT_SLOTS)'(bcd_next);
	assign hex_pad = (4*PADN)'(in_mag);
	// nonzero nibbles that do not fit in the digit slots
	assign hex_ovf = |(hex_pad & ~(4*PADN)'({(4*DIGIT_SLOTS){1'b1}}));

	// most significant nonzero digit, zero prints as one digit;
	// when upper digits were dropped every slot prints, zeros included
	always_comb begin
		msd = '0;
		for (int i = 0; i < DIGIT_SLOTS; i++)
			if (digits_q[i] != 4'd0)
				msd = PW'(i);
		if (ovf_q)
			msd = PW'(DIGIT_SLOTS-1);
		sum = 5'(msd) + 5'd1 + 5'(neg_q);
	end

	assign in_pop   = (state_q == IDLE) && !in_empty;
	assign out_push = (state_q == EMIT) && !out_full;
	assign is_last  = (5'(emit_cnt_q + 5'd1) == total_q);

	always_comb begin
		out_item.ch    = dash_q ? CH_MINUS : digit_char(digits_q[pos_q], upper_q);
		out_item.last  = is_last;
		out_item.count = is_last ? total_q : 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			bcd_q      <= '0;
			shift_q    <= '0;
			bit_cnt_q  <= '0;
			neg_q      <= 1'b0;
			upper_q    <= 1'b0;
			dash_q     <= 1'b0;
			ovf_q      <= 1'b0;
			pos_q      <= '0;
			emit_cnt_q <= '0;
			total_q    <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (!in_empty) begin
						neg_q   <= in_cls.neg;
						upper_q <= (in_cls.op == OP_HEXU);
						if (in_cls.op == OP_SDEC || in_cls.op == OP_UDEC) begin
							shift_q   <= in_mag[DEC_BITS-1:0];
							bcd_q     <= '0;
							bit_cnt_q <= '0;
							ovf_q     <= 1'b0;
							state_q   <= DEC;
						end else begin
							for (int i = 0; i < DIGIT_SLOTS; i++)
								digits_q[i] <= hex_pad[4*i +: 4];
							ovf_q   <= hex_ovf;
							state_q <= SCAN;
						end
					end
				end
				DEC: begin
					bcd_q     <= bcd_next;
					shift_q   <= {shift_q[DEC_BITS-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 5'd1;
					if (bit_cnt_q == 5'(DEC_BITS-1)) begin
						for (int i = 0; i < DIGIT_SLOTS; i++)
							digits_q[i] <= dec_pad[4*i +: 4];
						state_q <= SCAN;
					end
				end
				SCAN: begin
					pos_q      <= msd;
					dash_q     <= neg_q;
					emit_cnt_q <= '0;
					total_q    <= (sum > MAX_CHARS) ? MAX_CHARS : sum;
					state_q    <= EMIT;
				end
				EMIT: begin
					if (!out_full) begin
						emit_cnt_q <= emit_cnt_q + 5'd1;
						if (dash_q)
							dash_q <= 1'b0;
						else
							pos_q <= pos_q - 1'b1;
						if (is_last)
							state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter top level: front end, middle queue, back end and
// result queue. Depends on itfmt_pkg, itfmt_fifo, itfmt_front, itfmt_back.
//
// Usage:
//   Input queue: drive value and op with push; a beat is taken when push is
//   high and full is low. op selects signed decimal, unsigned decimal, or
//   lowercase / uppercase hex.
//   Result queue: while empty is low, char_out holds the oldest character;
//   pop takes it. Characters come most significant first; last marks the
//   final one, and char_count then holds the number of characters.
//   Flow: a decimal number is loaded, passes the bit-serial BCD converter and
//   the leading-zero scan, then its characters (up to 11) are emitted; a hex
//   number is loaded, scanned and emitted (up to 16 characters). The back end
//   holds one number at a time, so throughput is set by the BCD shifter and the
//   one-character-per-cycle emitter while the result queue has room.
//   The two-entry middle queue keeps accepting while the back end works.
//   If the receiver stops popping, the result queue fills and the emitter
//   waits; nothing is dropped. Reset empties both queues and idles the back end.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter import itfmt_pkg::*; #(
	parameter int VALUE_WIDTH = 64,
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] value,
	input  wire logic [1:0]  op,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       char_out,
	output logic             last,
	output logic [4:0]       char_count
);
	localparam int MID_W = VALUE_WIDTH + $bits(cls_t);

	logic [VALUE_WIDTH-1:0] f_mag, b_mag;
	cls_t                   f_cls, b_cls;
	logic [MID_W-1:0]       mid_out;
	logic                   mid_empty, mid_pop;
	logic                   res_full, res_push;
	char_t                  res_in, res_out;

	itfmt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.value (value),
		.op    (op),
		.mag   (f_mag),
		.cls   (f_cls)
	);

	itfmt_fifo #(.WIDTH(MID_W), .DEPTH(2)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({f_cls, f_mag}),
		.full   (full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	assign b_mag = mid_out[VALUE_WIDTH-1:0];
	assign b_cls = cls_t'(mid_out[MID_W-1:VALUE_WIDTH]);

	itfmt_back #(.VALUE_WIDTH(VALUE_WIDTH), .DIGIT_SLOTS(DIGIT_SLOTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (mid_empty),
		.in_pop   (mid_pop),
		.in_mag   (b_mag),
		.in_cls   (b_cls),
		.out_full (res_full),
		.out_push (res_push),
		.out_item (res_in)
	);

	itfmt_fifo #(.WIDTH($bits(char_t)), .DEPTH(2)) u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign char_out   = res_out.ch;
	assign last       = res_out.last;
	assign char_count = res_out.count;

	// count appears only on the final character of a number
	a_count_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (char_count == 5'd0))
		else $error("char_count set on a non-final character");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (char_count != 5'd0 && char_count <= MAX_CHARS))
		else $error("char_count out of range on final character");

	// a minus sign can only lead a signed-decimal number
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.ch == CH_MINUS) |-> !res_in.last)
		else $error("minus sign emitted as final character");
endmodule
`default_nettype wire

/* test/integer_to_ascii_formatter_tb.sv */
// Testbench for integer_to_ascii_formatter: directed and random numbers in all four modes,
// with a local text predictor and a beat-by-beat checker. Depends on itfmt_pkg and the RTL.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
	import itfmt_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [63:0] value;
	op_t         op;
	logic        empty;
	logic        pop;
	logic [7:0]  char_out;
	logic        last;
	logic [4:0]  char_count;

	char_t expected_chars[$];
	int    error_count = 0;
	int    idle_cycles = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    stall_left = 0;

	integer_to_ascii_formatter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.op         (op),
		.empty      (empty),
		.pop        (pop),
		.char_out   (char_out),
		.last       (last),
		.char_count (char_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	// expected text of one number, pushed as beats onto expected_chars
	function automatic void predict_text(input logic [63:0] v, input op_t o);
		logic [63:0] mag;
		logic        neg;
		int unsigned radix;
		logic [3:0]  digits[16];
		int          ndig;
		int          total;
		char_t       beat;
		logic [3:0]  d;

		neg = 1'b0;
		case (o)
			OP_SDEC: begin
				mag = {32'd0, v[31:0]};
				if (v[31]) begin
					neg = 1'b1;
					mag = {32'd0, 32'd0 - v[31:0]};
				end
				radix = 10;
			end
			OP_UDEC: begin
				mag = {32'd0, v[31:0]};
				radix = 10;
			end
			default: begin
				mag = v;
				radix = 16;
			end
		endcase

		ndig = 0;
		do begin
			if (ndig < 16) begin
				digits[ndig] = 4'(mag % radix);
				ndig++;
			end
			mag = mag / radix;
		end while (mag != 0);

		total = ndig + int'(neg);
		if (total > 16)
			total = 16;

		for (int k = 0; k < total; k++) begin
			if (neg && k == 0) begin
				beat.ch = "-";
			end else begin
				d = digits[ndig - 1 - (k - int'(neg))];
				if (d < 10)
					beat.ch = "0" + 8'(d);
				else if (o == OP_HEXU)
					beat.ch = "A" + 8'(d) - 8'd10;
				else
					beat.ch = "a" + 8'(d) - 8'd10;
			end
			beat.last = (k + 1 == total);
			beat.count = beat.last ? 5'(total) : 5'd0;
			expected_chars.push_back(beat);
		end
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int          bits;

		bits = $urandom_range(64, 0);
		v = {$urandom, $urandom};
		if (bits < 64)
			v = v & ((64'd1 << bits) - 64'd1);
		return v;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_number(input logic [63:0] v, input op_t o);
		int gap;

		gap = pick_gap(send_idle_pct);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		value <= v;
		op <= o;
		do @(posedge clk); while (full);
		predict_text(v, o);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(negedge clk); while (expected_chars.size() != 0);
	endtask

	task automatic test_extremes();
		send_idle_pct = 30;
		recv_stall_pct = 30;
		send_number(64'd0, OP_SDEC);
		send_number(64'd0, OP_UDEC);
		send_number(64'd0, OP_HEXL);
		send_number(64'd0, OP_HEXU);
		send_number(64'd1, OP_SDEC);
		send_number(64'h0000_0000_FFFF_FFFF, OP_SDEC);
		send_number(64'h0000_0000_7FFF_FFFF, OP_SDEC);
		send_number(64'h0000_0000_8000_0000, OP_SDEC);
		// upper half must not matter in decimal
		send_number(64'hFFFF_FFFF_8000_0000, OP_SDEC);
		send_number(64'hDEAD_BEEF_0000_0000, OP_SDEC);
		send_number(64'h0000_0000_FFFF_FFFF, OP_UDEC);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_UDEC);
		send_number(64'hDEAD_BEEF_0000_0000, OP_UDEC);
		send_number(64'd9, OP_UDEC);
		send_number(64'd10, OP_UDEC);
		send_number(64'd1_000_000_000, OP_UDEC);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_HEXL);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_HEXU);
		send_number(64'h0123_4567_89AB_CDEF, OP_HEXL);
		send_number(64'h0123_4567_89AB_CDEF, OP_HEXU);
		send_number(64'hFEDC_BA98_7654_3210, OP_HEXU);
		send_number(64'd15, OP_HEXL);
		send_number(64'd16, OP_HEXU);
		send_number(64'h8000_0000_0000_0000, OP_HEXL);
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 40; i++)
			send_number(rand_value(), op_t'($urandom_range(3)));
	endtask

	// sender holds off until the result side is empty, twice
	task automatic test_drain_pause();
		send_idle_pct = 20;
		recv_stall_pct = 40;
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < 8; i++)
				send_number(rand_value(), op_t'($urandom_range(3)));
			wait_drained();
		end
	endtask

	task automatic test_random_mix();
		logic [63:0] v;
		int          pick;

		for (int i = 0; i < 300; i++) begin
			if (i % 50 == 0) begin
				send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 10);
				recv_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 10);
			end
			pick = $urandom_range(19);
			if (pick == 0)
				v = {$urandom, 32'h8000_0000};
			else if (pick == 1)
				v = {$urandom, 32'hFFFF_FFFF};
			else
				v = rand_value();
			send_number(v, op_t'($urandom_range(3)));
		end
	endtask

	// receiver: pop high unless inside a stall
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = pick_gap(recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_beat
		char_t want;

		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				flag_error($sformatf("unexpected beat: char %02h last %0b count %0d",
					char_out, last, char_count));
			end else begin
				want = expected_chars.pop_front();
				if (char_out !== want.ch || last !== want.last || char_count !== want.count)
					flag_error($sformatf("mismatch: exp %02h/%0b/%0d got %02h/%0b/%0d",
						want.ch, want.last, want.count, char_out, last, char_count));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		value = 64'd0;
		op = OP_SDEC;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_back_to_back();
		test_drain_pause();
		test_random_mix();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_chars.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* integer_to_ascii_formatter.f */
hdl/itfmt_pkg.sv
hdl/itfmt_fifo.sv
hdl/itfmt_front.sv
hdl/itfmt_back.sv
hdl/integer_to_ascii_formatter.sv
test/integer_to_ascii_formatter_tb.sv
